/* src/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types and constants of the rgb / cmy / cmyk colour converter.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int unsigned QUO_W           = 14;  // widest quotient (0..10000)
  localparam int unsigned DEN_W           = 27;  // holds 100000000
  localparam int unsigned NUM_W           = 35;  // holds 255 * 10000 * 10000
  localparam int unsigned A_W             = 22;  // holds 255 * 10000
  localparam int unsigned PROD_W          = A_W + QUO_W;
  localparam int unsigned NUM_LANES       = 4;   // three channels and black
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QUO_W / STEPS_PER_STAGE;
  localparam int unsigned LATENCY         = DIV_STAGES + 3;

  localparam logic [QUO_W-1:0] FULL_SCALE = 14'd10000;
  localparam logic [7:0]       BYTE_MAX   = 8'd255;
  localparam logic [DEN_W-1:0] CMYK_DEN   = 27'd100000000;
  localparam logic [DEN_W-1:0] DEN_ONE    = 27'd1;
  localparam logic [QUO_W-1:0] MUL_ONE    = 14'd1;

  typedef enum logic [1:0] {
    MODE_RGB2CMYK = 2'd0,
    MODE_RGB2CMY  = 2'd1,
    MODE_CMYK2RGB = 2'd2,
    MODE_CMY2RGB  = 2'd3
  } rcc_mode_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [13:0] cyan_in;
    logic [13:0] magenta_in;
    logic [13:0] yellow_in;
    logic [13:0] black_in;
  } rcc_req_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [13:0] cyan_out;
    logic [13:0] magenta_out;
    logic [13:0] yellow_out;
    logic [13:0] black_out;
    logic        bad_input;
  } rcc_res_t;

  // control that travels alongside each beat
  typedef struct packed {
    rcc_mode_e mode;
    logic      bad;
  } rcc_ctl_t;

  // one restoring divider lane: partial remainder, dividend bits turning into
  // quotient bits, divisor
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] work;
    logic [DEN_W-1:0] den;
  } rcc_lane_t;

  typedef rcc_lane_t [NUM_LANES-1:0] rcc_lanes_t;

endpackage

/* src/rgb_cmyk_color_converter_core.sv */
// ----------------------------------------------------------------------------
// rgb_cmyk_color_converter_core
// Pipelined converter between rgb bytes and cmy / cmyk in hundredths of a
// percent.
// ----------------------------------------------------------------------------
// A beat is taken on every rising edge with start_i high and busy_o low;
// busy_o stays low, so a new beat can be issued every cycle. req_i carries
// the mode (req_type) and the source components; fields the mode does not
// use are ignored.
// Each beat gives one result on res_o, marked by done_o for one cycle,
// after passing one stage for max and range check, one for the dividend
// multiply, seven divider stages of two quotient bits each and one output
// register. Throughput is one beat per cycle, set by the fully pipelined
// restoring divider lanes.
// Results leave in issue order. The receiver cannot hold a result off, so
// there is no back pressure anywhere in the pipe.
// Reset clears all valid bits; beats in flight are dropped and no done_o
// strobe follows until new beats are issued.
// ----------------------------------------------------------------------------
module rgb_cmyk_color_converter_core import rcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  rcc_req_t req_i,
  output logic     done_o,
  output rcc_res_t res_o
);

  logic       fr_valid;
  rcc_ctl_t   fr_ctl;
  rcc_lanes_t fr_lanes;

  logic       st_valid [DIV_STAGES+1];
  rcc_ctl_t   st_ctl   [DIV_STAGES+1];
  rcc_lanes_t st_lanes [DIV_STAGES+1];

  logic       done_q;
  rcc_res_t   res_d, res_q;
  rcc_ctl_t   out_ctl;
  rcc_lanes_t out_lanes;

  assign busy_o = 1'b0;

  rcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (req_i),
    .valid_o (fr_valid),
    .ctl_o   (fr_ctl),
    .lanes_o (fr_lanes)
  );

  assign st_valid[0] = fr_valid;
  assign st_ctl[0]   = fr_ctl;
  assign st_lanes[0] = fr_lanes;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rcc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .ctl_i   (st_ctl[g]),
      .lanes_i (st_lanes[g]),
      .valid_o (st_valid[g+1]),
      .ctl_o   (st_ctl[g+1]),
      .lanes_o (st_lanes[g+1])
    );
  end

  assign out_ctl   = st_ctl[DIV_STAGES];
  assign out_lanes = st_lanes[DIV_STAGES];

  // killed lanes already hold a zero quotient
  always_comb begin
    res_d           = '0;
    res_d.bad_input = out_ctl.bad;
    unique case (out_ctl.mode)
      MODE_RGB2CMYK: begin
        res_d.cyan_out    = out_lanes[0].work;
        res_d.magenta_out = out_lanes[1].work;
        res_d.yellow_out  = out_lanes[2].work;
        res_d.black_out   = out_lanes[3].work;
      end
      MODE_RGB2CMY: begin
        res_d.cyan_out    = out_lanes[0].work;
        res_d.magenta_out = out_lanes[1].work;
        res_d.yellow_out  = out_lanes[2].work;
      end
      MODE_CMYK2RGB,
      MODE_CMY2RGB: begin
        res_d.red_out   = out_lanes[0].work[7:0];
        res_d.green_out = out_lanes[1].work[7:0];
        res_d.blue_out  = out_lanes[2].work[7:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= st_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result strobe missing after fixed latency");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.bad_input) |->
      (res_o.red_out == 8'd0 && res_o.green_out == 8'd0 && res_o.blue_out == 8'd0 &&
       res_o.cyan_out == '0 && res_o.magenta_out == '0 && res_o.yellow_out == '0 &&
       res_o.black_out == '0))
    else $error("bad input result carries non-zero components");

  a_rgb_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid[DIV_STAGES] &&
     (out_ctl.mode == MODE_CMYK2RGB || out_ctl.mode == MODE_CMY2RGB)) |->
      (out_lanes[0].work[QUO_W-1:8] == '0 && out_lanes[1].work[QUO_W-1:8] == '0 &&
       out_lanes[2].work[QUO_W-1:8] == '0))
    else $error("rgb quotient exceeds a byte");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid[DIV_STAGES] &&
     (out_ctl.mode == MODE_RGB2CMYK || out_ctl.mode == MODE_RGB2CMY)) |->
      (out_lanes[0].work <= FULL_SCALE && out_lanes[1].work <= FULL_SCALE &&
       out_lanes[2].work <= FULL_SCALE && out_lanes[3].work <= FULL_SCALE))
    else $error("percentage quotient above full scale");
`endif

endmodule

/* src/rcc_front.sv */
// ----------------------------------------------------------------------------
// rcc_front
// First two pipeline stages: max and range check, then dividend and divisor.
// ----------------------------------------------------------------------------
module rcc_front import rcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rcc_req_t   req_i,
  output logic       valid_o,
  output rcc_ctl_t   ctl_o,
  output rcc_lanes_t lanes_o
);

  logic [7:0]                      rgb_v [3];
  logic [QUO_W-1:0]                cmy_v [3];
  logic [QUO_W-1:0]                inv_v [3];
  logic [7:0]                      mx_d, mx_q;
  logic                            cmy_over, k_over;
  rcc_ctl_t                        ctl_d, ctl_q;
  logic [NUM_LANES-1:0][A_W-1:0]   a_d, a_q;
  logic                            valid_q;

  logic [QUO_W-1:0]                mul_b;
  logic [PROD_W-1:0]               prod [NUM_LANES];
  logic                            kill [NUM_LANES];
  rcc_lanes_t                      lanes_d, lanes_q;
  logic                            valid2_q;
  rcc_ctl_t                        ctl2_q;

  // stage one
  always_comb begin
    rgb_v[0] = req_i.red_in;
    rgb_v[1] = req_i.green_in;
    rgb_v[2] = req_i.blue_in;
    cmy_v[0] = req_i.cyan_in;
    cmy_v[1] = req_i.magenta_in;
    cmy_v[2] = req_i.yellow_in;

    mx_d = (req_i.red_in >= req_i.green_in) ? req_i.red_in : req_i.green_in;
    if (req_i.blue_in > mx_d) begin
      mx_d = req_i.blue_in;
    end

    cmy_over = (req_i.cyan_in > FULL_SCALE) || (req_i.magenta_in > FULL_SCALE) ||
               (req_i.yellow_in > FULL_SCALE);
    k_over   = req_i.black_in > FULL_SCALE;

    ctl_d.mode = rcc_mode_e'(req_i.req_type);
    ctl_d.bad  = ((ctl_d.mode == MODE_CMYK2RGB) && (cmy_over || k_over)) ||
                 ((ctl_d.mode == MODE_CMY2RGB) && cmy_over);

    for (int l = 0; l < 3; l++) begin
      inv_v[l] = FULL_SCALE - cmy_v[l];
      unique case (ctl_d.mode)
        MODE_RGB2CMYK: a_d[l] = {{(A_W-8){1'b0}}, mx_d - rgb_v[l]};
        MODE_RGB2CMY:  a_d[l] = {{(A_W-8){1'b0}}, BYTE_MAX - rgb_v[l]};
        MODE_CMYK2RGB,
        MODE_CMY2RGB:  a_d[l] = {inv_v[l], 8'b0} - {8'b0, inv_v[l]};  // times 255
      endcase
    end

    if (ctl_d.mode == MODE_RGB2CMYK) begin
      a_d[3] = {{(A_W-8){1'b0}}, BYTE_MAX - mx_d};
    end else begin
      a_d[3] = {{(A_W-QUO_W){1'b0}}, FULL_SCALE - req_i.black_in};
    end
  end

  // stage two: one multiply per lane, then divisor selection
  always_comb begin
    unique case (ctl_q.mode)
      MODE_RGB2CMYK,
      MODE_RGB2CMY:  mul_b = FULL_SCALE;
      MODE_CMYK2RGB: mul_b = a_q[3][QUO_W-1:0];
      MODE_CMY2RGB:  mul_b = MUL_ONE;
    endcase

    for (int l = 0; l < NUM_LANES; l++) begin
      prod[l] = a_q[l] * mul_b;
      unique case (ctl_q.mode)
        MODE_RGB2CMYK: lanes_d[l].den = (l == 3) ? {{(DEN_W-8){1'b0}}, BYTE_MAX}
                                                 : {{(DEN_W-8){1'b0}}, mx_q};
        MODE_RGB2CMY:  lanes_d[l].den = {{(DEN_W-8){1'b0}}, BYTE_MAX};
        MODE_CMYK2RGB: lanes_d[l].den = CMYK_DEN;
        MODE_CMY2RGB:  lanes_d[l].den = {{(DEN_W-QUO_W){1'b0}}, FULL_SCALE};
      endcase
      // black lane only works in rgb to cmyk; a black pixel gives zero cmy
      kill[l] = ctl_q.bad ||
                ((l == 3) && (ctl_q.mode != MODE_RGB2CMYK)) ||
                ((l != 3) && (ctl_q.mode == MODE_RGB2CMYK) && (mx_q == 8'd0));
      if (kill[l]) begin
        lanes_d[l].rem  = '0;
        lanes_d[l].work = '0;
        lanes_d[l].den  = DEN_ONE;
      end else begin
        lanes_d[l].rem  = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, prod[l][NUM_W-1:QUO_W]};
        lanes_d[l].work = prod[l][QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q   <= ctl_d;
    mx_q    <= mx_d;
    a_q     <= a_d;
    ctl2_q  <= ctl_q;
    lanes_q <= lanes_d;
  end

  assign valid_o = valid2_q;
  assign ctl_o   = ctl2_q;
  assign lanes_o = lanes_q;

endmodule

/* src/rcc_div_stage.sv */
// ----------------------------------------------------------------------------
// rcc_div_stage
// One register stage of the restoring divider, two quotient bits per lane.
// ----------------------------------------------------------------------------
module rcc_div_stage import rcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rcc_ctl_t   ctl_i,
  input  rcc_lanes_t lanes_i,
  output logic       valid_o,
  output rcc_ctl_t   ctl_o,
  output rcc_lanes_t lanes_o
);

  rcc_lanes_t     lanes_d, lanes_q;
  rcc_ctl_t       ctl_q;
  logic           valid_q;
  logic [DEN_W:0] rem_sh;
  logic           ge;

  always_comb begin
    lanes_d = lanes_i;
    rem_sh  = '0;
    ge      = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        rem_sh = {lanes_d[l].rem, lanes_d[l].work[QUO_W-1]};
        ge     = rem_sh >= {1'b0, lanes_d[l].den};
        if (ge) begin
          rem_sh = rem_sh - {1'b0, lanes_d[l].den};
        end
        lanes_d[l].rem  = rem_sh[DEN_W-1:0];
        lanes_d[l].work = {lanes_d[l].work[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q   <= ctl_i;
    lanes_q <= lanes_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign lanes_o = lanes_q;

endmodule

/* tb/rgb_cmyk_color_converter_core_tb.sv */
// ----------------------------------------------------------------------------
// rgb_cmyk_color_converter_core_tb
// Self-checking bench for the colour converter: a queue-fed driver issues
// directed corner pixels and then random pixels with random gaps, a monitor
// predicts each accepted beat and compares every field of every done_o beat
// in issue order.
// ----------------------------------------------------------------------------
module rgb_cmyk_color_converter_core_tb;
  import rcc_pkg::*;

  localparam int unsigned    RANDOM_PIXELS = 1500;
  localparam int unsigned    MAX_GAP       = 15;
  localparam int unsigned    REPORT_LIMIT  = 10;
  localparam int unsigned    RUN_LIMIT     = 2000000;
  localparam longint unsigned PCT_SCALE    = 10000;
  localparam longint unsigned BYTE_TOP     = 255;
  localparam int unsigned    PCT_FIELD_TOP = 16383;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  rcc_req_t req_i   = '0;
  logic     done_o;
  rcc_res_t res_o;

  rcc_req_t    pending_pixels[$];
  rcc_res_t    expected_colours[$];
  int unsigned gap_left   = 0;
  bit          steady_run = 1'b0;
  int unsigned n_fail     = 0;

  rgb_cmyk_color_converter_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic rcc_res_t convert_pixel(rcc_req_t px);
    longint unsigned r, g, b, c, m, y, k, mx;
    rcc_res_t res;
    res = '0;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    c = px.cyan_in;
    m = px.magenta_in;
    y = px.yellow_in;
    k = px.black_in;
    case (rcc_mode_e'(px.req_type))
      MODE_RGB2CMYK: begin
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        res.black_out = 14'((BYTE_TOP - mx) * PCT_SCALE / BYTE_TOP);
        // black pixel: no division, c m y stay zero
        if (mx != 0) begin
          res.cyan_out    = 14'((mx - r) * PCT_SCALE / mx);
          res.magenta_out = 14'((mx - g) * PCT_SCALE / mx);
          res.yellow_out  = 14'((mx - b) * PCT_SCALE / mx);
        end
      end
      MODE_RGB2CMY: begin
        res.cyan_out    = 14'((BYTE_TOP - r) * PCT_SCALE / BYTE_TOP);
        res.magenta_out = 14'((BYTE_TOP - g) * PCT_SCALE / BYTE_TOP);
        res.yellow_out  = 14'((BYTE_TOP - b) * PCT_SCALE / BYTE_TOP);
      end
      MODE_CMYK2RGB: begin
        if (c > PCT_SCALE || m > PCT_SCALE || y > PCT_SCALE || k > PCT_SCALE) begin
          res.bad_input = 1'b1;
        end else begin
          res.red_out   = 8'(BYTE_TOP * (PCT_SCALE - c) * (PCT_SCALE - k) /
                             (PCT_SCALE * PCT_SCALE));
          res.green_out = 8'(BYTE_TOP * (PCT_SCALE - m) * (PCT_SCALE - k) /
                             (PCT_SCALE * PCT_SCALE));
          res.blue_out  = 8'(BYTE_TOP * (PCT_SCALE - y) * (PCT_SCALE - k) /
                             (PCT_SCALE * PCT_SCALE));
        end
      end
      MODE_CMY2RGB: begin
        // black_in is not looked at here
        if (c > PCT_SCALE || m > PCT_SCALE || y > PCT_SCALE) begin
          res.bad_input = 1'b1;
        end else begin
          res.red_out   = 8'(BYTE_TOP * (PCT_SCALE - c) / PCT_SCALE);
          res.green_out = 8'(BYTE_TOP * (PCT_SCALE - m) / PCT_SCALE);
          res.blue_out  = 8'(BYTE_TOP * (PCT_SCALE - y) / PCT_SCALE);
        end
      end
    endcase
    return res;
  endfunction

  task automatic add_pixel(rcc_mode_e mode, int unsigned r, int unsigned g,
                           int unsigned b, int unsigned c, int unsigned m,
                           int unsigned y, int unsigned k);
    rcc_req_t px;
    px.req_type   = mode;
    px.red_in     = 8'(r);
    px.green_in   = 8'(g);
    px.blue_in    = 8'(b);
    px.cyan_in    = 14'(c);
    px.magenta_in = 14'(m);
    px.yellow_in  = 14'(y);
    px.black_in   = 14'(k);
    pending_pixels.push_back(px);
  endtask

  function automatic int unsigned any_byte();
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned any_pct_field();
    return $urandom_range(0, PCT_FIELD_TOP);
  endfunction

  // mostly dark-ish or full-range bytes, so small maxima get exercised
  function automatic int unsigned rand_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 7);
    return $urandom_range(0, 255);
  endfunction

  // mostly legal percentages, edges now and then, the odd out-of-range one
  function automatic int unsigned rand_pct();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(32'(PCT_SCALE) + 32'd1, PCT_FIELD_TOP);
      1:       return 0;
      2:       return 32'(PCT_SCALE);
      default: return $urandom_range(0, 32'(PCT_SCALE));
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 39) == 0) steady_run = !steady_run;
    if (steady_run) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) begin
      n_fail++;
      if (n_fail <= REPORT_LIMIT)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // driver: one beat per pending pixel, random idle cycles between beats
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      // hold the beat until it is taken
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start_i  <= 1'b0;
    end else if (pending_pixels.size() != 0) begin
      req_i    <= pending_pixels.pop_front();
      start_i  <= 1'b1;
      gap_left <= draw_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: check the result beat first, then record the beat taken now
  always @(posedge clk_i) begin
    rcc_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_colours.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT)
            $display("unexpected result beat: got %h", res_o);
        end else begin
          want = expected_colours.pop_front();
          check_field("red_out",     res_o.red_out,     want.red_out);
          check_field("green_out",   res_o.green_out,   want.green_out);
          check_field("blue_out",    res_o.blue_out,    want.blue_out);
          check_field("cyan_out",    res_o.cyan_out,    want.cyan_out);
          check_field("magenta_out", res_o.magenta_out, want.magenta_out);
          check_field("yellow_out",  res_o.yellow_out,  want.yellow_out);
          check_field("black_out",   res_o.black_out,   want.black_out);
          check_field("bad_input",   res_o.bad_input,   want.bad_input);
        end
      end
      if (start_i && !busy_o) expected_colours.push_back(convert_pixel(req_i));
    end
  end

  initial begin
    rcc_mode_e mode;
    // rgb to cmyk corners, black pixel among them
    add_pixel(MODE_RGB2CMYK, 0, 0, 0, any_pct_field(), any_pct_field(),
              any_pct_field(), any_pct_field());
    add_pixel(MODE_RGB2CMYK, 255, 255, 255, 16383, 16383, 16383, 16383);
    add_pixel(MODE_RGB2CMYK, 255, 0, 0, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMYK, 0, 255, 0, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMYK, 0, 0, 255, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMYK, 1, 0, 0, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMYK, 1, 1, 1, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMYK, 254, 17, 200, 12345, 0, 9, 16383);
    // rgb to cmy
    add_pixel(MODE_RGB2CMY, 0, 0, 0, 16383, 16383, 16383, 16383);
    add_pixel(MODE_RGB2CMY, 255, 255, 255, 0, 0, 0, 0);
    add_pixel(MODE_RGB2CMY, 0, 128, 255, 0, 0, 0, 0);
    // cmyk to rgb, range edges and each field out of range
    add_pixel(MODE_CMYK2RGB, 255, 255, 255, 0, 0, 0, 0);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 10000, 10000, 10000, 10000);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 10000, 0, 5000, 0);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 0, 0, 0, 10000);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 10001, 0, 0, 0);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 0, 0, 10001, 0);
    add_pixel(MODE_CMYK2RGB, 0, 0, 0, 0, 0, 0, 10001);
    add_pixel(MODE_CMYK2RGB, 255, 255, 255, 16383, 16383, 16383, 16383);
    // cmy to rgb, black_in ignored even when out of range
    add_pixel(MODE_CMY2RGB, 255, 255, 255, 0, 0, 0, 16383);
    add_pixel(MODE_CMY2RGB, 0, 0, 0, 10000, 10000, 10000, 0);
    add_pixel(MODE_CMY2RGB, 0, 0, 0, 1, 9999, 5000, 0);
    add_pixel(MODE_CMY2RGB, 0, 0, 0, 0, 10001, 0, 0);
    add_pixel(MODE_CMY2RGB, 0, 0, 0, 16383, 0, 0, 0);

    repeat (RANDOM_PIXELS) begin
      mode = rcc_mode_e'($urandom_range(0, 3));
      case (mode)
        MODE_RGB2CMYK, MODE_RGB2CMY:
          add_pixel(mode, rand_byte(), rand_byte(), rand_byte(), any_pct_field(),
                    any_pct_field(), any_pct_field(), any_pct_field());
        MODE_CMYK2RGB:
          add_pixel(mode, any_byte(), any_byte(), any_byte(), rand_pct(), rand_pct(),
                    rand_pct(), rand_pct());
        MODE_CMY2RGB:
          add_pixel(mode, any_byte(), any_byte(), any_byte(), rand_pct(), rand_pct(),
                    rand_pct(), any_pct_field());
      endcase
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_pixels.size() != 0 || start_i || expected_colours.size() != 0);
    repeat (LATENCY + 4) @(posedge clk_i);

    if (n_fail == 0 && expected_colours.size() == 0) begin
      $display("[rgb_cmyk_color_converter_core] OK");
    end else begin
      $display("[rgb_cmyk_color_converter_core] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[rgb_cmyk_color_converter_core] ERROR");
    $finish;
  end

endmodule
